### rtl/pd_torque_limited_position_target_macros.svh
// Assertion macros used by the checker of this block.
`ifndef PD_TORQUE_LIMITED_POSITION_TARGET_MACROS_SVH
`define PD_TORQUE_LIMITED_POSITION_TARGET_MACROS_SVH

// Condition that must hold at every clock edge, reset included.
`define PDTL_ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PDTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pdtl_pkg.sv
`default_nettype none

package pdtl_pkg;

  // Quotient bits resolved by each divider; larger quotients always saturate.
  localparam int QBITS = 34;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_HOLD,
    CLS_CLIP
  } cls_e;

  typedef enum logic {
    REG_CLIP_EN  = 1'b0,
    REG_CAP_FRAC = 1'b1
  } reg_e;

  // One classified joint, handed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] res;
    logic signed [31:0] pos;
    logic signed [31:0] kp;
    logic signed [63:0] b;
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        cap;
    logic [63:0]        full;
    cls_e               cls;
  } pdtl_job_t;

  // Context that rides along the back pipeline and through the dividers.
  typedef struct packed {
    logic signed [31:0] res;
    logic signed [31:0] pos;
    logic signed [31:0] kp;
    logic signed [63:0] b;
    logic [63:0]        full;
    logic               clip1;
    logic               clip2;
    logic               active;
    logic               qneg;
  } pdtl_ctx_t;

endpackage

`default_nettype wire

### rtl/pdtl_front.sv
`default_nettype none

module pdtl_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    target_pos_i,
  input  logic signed [31:0]    current_pos_i,
  input  logic signed [31:0]    current_vel_i,
  input  logic signed [31:0]    stiffness_gain_i,
  input  logic signed [31:0]    damping_gain_i,
  input  logic [30:0]           torque_limit_i,
  input  logic                  clip_enable_i,
  input  logic [16:0]           cap_fraction_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output pdtl_pkg::pdtl_job_t   job_o
);

  localparam int UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  logic signed [32:0] diff_w;
  logic signed [64:0] prod_a_w;
  logic signed [63:0] prod_b_w;
  logic [47:0]        capp_w;
  pdtl_pkg::cls_e     cls_w;
  logic               ce;

  logic               v1_q, v2_q;
  logic signed [64:0] a1_q;
  logic signed [63:0] b1_q;
  logic [47:0]        capp1_q;
  logic [30:0]        lim1_q;
  logic signed [31:0] qt1_q, q1_q, kp1_q;
  pdtl_pkg::cls_e     cls1_q;

  logic signed [65:0]  tau_w;
  pdtl_pkg::pdtl_job_t job_d, job_q;

  assign diff_w   = 33'(target_pos_i) - 33'(current_pos_i);
  assign prod_a_w = 65'(stiffness_gain_i) * 65'(diff_w);
  assign prod_b_w = 64'(damping_gain_i) * 64'(current_vel_i);
  assign capp_w   = 48'(cap_fraction_i) * 48'(torque_limit_i);

  always_comb begin
    if (!clip_enable_i || torque_limit_i == '0) begin
      cls_w = pdtl_pkg::CLS_PASS;
    end else if (stiffness_gain_i == '0) begin
      cls_w = pdtl_pkg::CLS_HOLD;
    end else begin
      cls_w = pdtl_pkg::CLS_CLIP;
    end
  end

  assign ce         = !(v2_q && !job_ready_i);
  assign in_ready_o = ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ce) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      a1_q    <= prod_a_w;
      b1_q    <= prod_b_w;
      capp1_q <= capp_w;
      lim1_q  <= torque_limit_i;
      qt1_q   <= target_pos_i;
      q1_q    <= current_pos_i;
      kp1_q   <= stiffness_gain_i;
      cls1_q  <= cls_w;
      job_q   <= job_d;
    end
  end

  // Torque as sign and magnitude, plus both clamp levels.
  always_comb begin
    tau_w      = 66'(a1_q) - 66'(b1_q);
    job_d.res  = (cls1_q == pdtl_pkg::CLS_HOLD) ? q1_q : qt1_q;
    job_d.pos  = q1_q;
    job_d.kp   = kp1_q;
    job_d.b    = b1_q;
    job_d.neg  = tau_w[65];
    job_d.mag  = tau_w[65] ? 64'(-tau_w) : 64'(tau_w);
    job_d.cap  = (64'(capp1_q) << UP) >> DOWN;
    job_d.full = 64'(lim1_q) << FRAC_BITS;
    job_d.cls  = cls1_q;
  end

  assign job_valid_o = v2_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

### rtl/pdtl_fifo.sv
`default_nettype none

module pdtl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  pdtl_pkg::pdtl_job_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output pdtl_pkg::pdtl_job_t rd_data_o
);

  localparam int AW = $clog2(pdtl_pkg::FIFO_DEPTH);

  pdtl_pkg::pdtl_job_t mem_q [pdtl_pkg::FIFO_DEPTH];
  logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [AW:0]         cnt_q;
  logic                push, pop;

  assign wr_ready_o = cnt_q != (AW+1)'(pdtl_pkg::FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/pdtl_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
module pdtl_div #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ce_i,
  input  logic                       valid_i,
  input  logic [63:0]                num_i,
  input  logic [31:0]                den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [pdtl_pkg::QBITS-1:0] quo_o,
  output logic                       ovf_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int QB = pdtl_pkg::QBITS;

  logic [QB:0]        v_q;
  logic [63:0]        rem_q  [QB+1];
  logic [31:0]        den_q  [QB+1];
  logic [QB-1:0]      quo_q  [QB+1];
  logic               ovf_q  [QB+1];
  logic [SIDE_W-1:0]  side_q [QB+1];
  logic [65:0]        sub_w  [QB+1];
  logic               ge_w   [QB+1];

  always_comb begin
    sub_w[0] = '0;
    ge_w[0]  = 1'b0;
    for (int s = 1; s <= QB; s++) begin
      sub_w[s] = 66'(den_q[s-1]) << (QB - s);
      ge_w[s]  = {2'b00, rem_q[s-1]} >= sub_w[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ce_i) begin
      v_q <= {v_q[QB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= {2'b00, num_i} >= (66'(den_i) << QB);
      side_q[0] <= side_i;
      for (int s = 1; s <= QB; s++) begin
        rem_q[s]  <= ge_w[s] ? rem_q[s-1] - sub_w[s][63:0] : rem_q[s-1];
        den_q[s]  <= den_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (QB'(ge_w[s]) << (QB - s));
        ovf_q[s]  <= ovf_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[QB];
  assign quo_o   = quo_q[QB];
  assign ovf_o   = ovf_q[QB];
  assign side_o  = side_q[QB];

endmodule

`default_nettype wire

### rtl/pdtl_back.sv
`default_nettype none

module pdtl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  pdtl_pkg::pdtl_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  res_o,
  output logic                clipped_o
);

  localparam int SW = $bits(pdtl_pkg::pdtl_ctx_t);
  localparam int QB = pdtl_pkg::QBITS;

  // Numerator of a back-solve (+-cap + kd*dq) as sign and magnitude.
  function automatic logic [64:0] solve_num(input logic neg, input logic [63:0] cap,
                                            input logic signed [63:0] b);
    logic signed [65:0] t;
    logic signed [65:0] n;
    t = $signed({2'b00, cap});
    n = (neg ? -t : t) + 66'(b);
    return {n[65], n[65] ? 64'(-n) : 64'(n)};
  endfunction

  // pos + signed quotient, saturated to 32 bits.
  function automatic logic signed [31:0] sat_res(input logic signed [31:0] pos,
                                                 input logic qneg, input logic ovf,
                                                 input logic [QB-1:0] quo);
    logic signed [QB+2:0] qv;
    logic signed [QB+2:0] s;
    logic signed [31:0]   r;
    qv = $signed({3'b000, quo});
    if (qneg) begin
      qv = -qv;
    end
    s = (QB+3)'(pos) + qv;
    if (ovf) begin
      r = qneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (s[QB+2:31] != {(QB-28){s[QB+2]}}) begin
      r = s[QB+2] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  logic ce;
  logic out_v_q;

  // Stage 1: first clamp decision and first back-solve numerator.
  logic [64:0]           n1_w;
  logic                  b1_v_q;
  logic [63:0]           b1_num_q;
  logic [31:0]           b1_den_q;
  pdtl_pkg::pdtl_ctx_t   c1_d, b1_ctx_q;

  logic                  d1_v;
  logic [QB-1:0]         d1_quo;
  logic                  d1_ovf;
  logic [SW-1:0]         d1_side;
  pdtl_pkg::pdtl_ctx_t   d1_ctx;

  // Stages 2 to 5: apply first result, recompute torque, second clamp.
  pdtl_pkg::pdtl_ctx_t   c2_d, b2_ctx_q, b3_ctx_q, b4_ctx_q, c5_d, b5_ctx_q;
  logic                  b2_v_q, b3_v_q, b4_v_q, b5_v_q;
  logic signed [32:0]    diff2_w;
  logic signed [64:0]    b3_a_q;
  logic signed [65:0]    tau2_w;
  logic                  b4_neg_q;
  logic [63:0]           b4_mag_q;
  logic [64:0]           n2_w;
  logic [63:0]           b5_num_q;
  logic [31:0]           b5_den_q;

  logic                  d2_v;
  logic [QB-1:0]         d2_quo;
  logic                  d2_ovf;
  logic [SW-1:0]         d2_side;
  pdtl_pkg::pdtl_ctx_t   d2_ctx;

  logic signed [31:0]    out_res_q;
  logic                  out_clip_q;

  assign ce          = !out_v_q || out_ready_i;
  assign job_ready_o = ce;

  always_comb begin
    n1_w         = solve_num(job_i.neg, job_i.cap, job_i.b);
    c1_d.res     = job_i.res;
    c1_d.pos     = job_i.pos;
    c1_d.kp      = job_i.kp;
    c1_d.b       = job_i.b;
    c1_d.full    = job_i.full;
    c1_d.active  = job_i.cls == pdtl_pkg::CLS_CLIP;
    c1_d.clip1   = c1_d.active && (job_i.mag > job_i.cap);
    c1_d.clip2   = 1'b0;
    c1_d.qneg    = n1_w[64] ^ job_i.kp[31];
  end

  pdtl_div #(.SIDE_W(SW)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (b1_v_q),
    .num_i   (b1_num_q),
    .den_i   (b1_den_q),
    .side_i  (SW'(b1_ctx_q)),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .ovf_o   (d1_ovf),
    .side_o  (d1_side)
  );

  assign d1_ctx = pdtl_pkg::pdtl_ctx_t'(d1_side);

  always_comb begin
    c2_d = d1_ctx;
    if (d1_ctx.clip1) begin
      c2_d.res = sat_res(d1_ctx.pos, d1_ctx.qneg, d1_ovf, d1_quo);
    end
  end

  assign diff2_w = 33'(b2_ctx_q.res) - 33'(b2_ctx_q.pos);
  assign tau2_w  = 66'(b3_a_q) - 66'(b3_ctx_q.b);

  always_comb begin
    n2_w       = solve_num(b4_neg_q, b4_ctx_q.full, b4_ctx_q.b);
    c5_d       = b4_ctx_q;
    c5_d.clip2 = b4_ctx_q.active && (b4_mag_q > b4_ctx_q.full);
    c5_d.qneg  = n2_w[64] ^ b4_ctx_q.kp[31];
  end

  pdtl_div #(.SIDE_W(SW)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (b5_v_q),
    .num_i   (b5_num_q),
    .den_i   (b5_den_q),
    .side_i  (SW'(b5_ctx_q)),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .ovf_o   (d2_ovf),
    .side_o  (d2_side)
  );

  assign d2_ctx = pdtl_pkg::pdtl_ctx_t'(d2_side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      b5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (ce) begin
      b1_v_q  <= job_valid_i;
      b2_v_q  <= d1_v;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      b5_v_q  <= b4_v_q;
      out_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      b1_num_q   <= n1_w[63:0];
      b1_den_q   <= job_i.kp[31] ? 32'(-job_i.kp) : 32'(job_i.kp);
      b1_ctx_q   <= c1_d;
      b2_ctx_q   <= c2_d;
      b3_a_q     <= 65'(b2_ctx_q.kp) * 65'(diff2_w);
      b3_ctx_q   <= b2_ctx_q;
      b4_neg_q   <= tau2_w[65];
      b4_mag_q   <= tau2_w[65] ? 64'(-tau2_w) : 64'(tau2_w);
      b4_ctx_q   <= b3_ctx_q;
      b5_num_q   <= n2_w[63:0];
      b5_den_q   <= b4_ctx_q.kp[31] ? 32'(-b4_ctx_q.kp) : 32'(b4_ctx_q.kp);
      b5_ctx_q   <= c5_d;
      out_res_q  <= d2_ctx.clip2 ? sat_res(d2_ctx.pos, d2_ctx.qneg, d2_ovf, d2_quo)
                                 : d2_ctx.res;
      out_clip_q <= d2_ctx.clip1 || d2_ctx.clip2;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_res_q;
  assign clipped_o   = out_clip_q;

endmodule

`default_nettype wire

### rtl/pd_torque_limited_position_target.sv
// Path from input transfer to output valid: two front stages, the queue, and a back
// pipeline holding two 35-stage dividers plus six other stages.
// Throughput: one joint per cycle; the back pipeline stalls as a whole on output backpressure.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and queue, sets
// clip_enable to 0 and cap_fraction to 65536.
`default_nettype none

module pd_torque_limited_position_target #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input item stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: target_pos[31:0], current_pos[63:32], current_vel[95:64],
  // stiffness_gain[127:96], damping_gain[159:128], torque_limit[190:160], zero pad.
  input  logic [191:0] s_axis_tdata,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: adjusted_pos[31:0].
  output logic [31:0]  m_axis_tdata,
  // From bit 0: was_clipped[0].
  output logic [0:0]   m_axis_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                clip_en_q;
  logic [16:0]         cap_frac_q;
  pdtl_pkg::reg_e      reg_sel;
  logic                cfg_wr;

  logic                job_valid, job_ready;
  pdtl_pkg::pdtl_job_t job;
  logic                q_valid, q_ready;
  pdtl_pkg::pdtl_job_t q_job;
  logic signed [31:0]  res;
  logic                clipped;

  // Registers sit at byte addresses 0 and 4, so bit 2 selects one.
  assign reg_sel = pdtl_pkg::reg_e'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_en_q  <= 1'b0;
      cap_frac_q <= 17'h1_0000;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        pdtl_pkg::REG_CLIP_EN:  clip_en_q  <= pwdata[0];
        pdtl_pkg::REG_CAP_FRAC: cap_frac_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pdtl_pkg::REG_CLIP_EN:  prdata = {31'b0, clip_en_q};
      pdtl_pkg::REG_CAP_FRAC: prdata = {15'b0, cap_frac_q};
      default:                prdata = '0;
    endcase
  end

  // The front part forms the PD torque and classifies the joint: passed through,
  // held at the current position, or subject to clipping.
  pdtl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .target_pos_i     (s_axis_tdata[31:0]),
    .current_pos_i    (s_axis_tdata[63:32]),
    .current_vel_i    (s_axis_tdata[95:64]),
    .stiffness_gain_i (s_axis_tdata[127:96]),
    .damping_gain_i   (s_axis_tdata[159:128]),
    .torque_limit_i   (s_axis_tdata[190:160]),
    .clip_enable_i    (clip_en_q),
    .cap_fraction_i   (cap_frac_q),
    .job_valid_o      (job_valid),
    .job_ready_i      (job_ready),
    .job_o            (job)
  );

  // A short queue lets the front keep accepting transfers while the back stalls.
  pdtl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_valid),
    .wr_ready_o (job_ready),
    .wr_data_i  (job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  // The back part applies both clamps, each with a pipelined back-solve
  // division, and holds the result in its output register.
  pdtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .clipped_o   (clipped)
  );

  assign m_axis_tdata = res;
  assign m_axis_tuser = clipped;

endmodule

`default_nettype wire

### rtl/pdtl_chk.sv
`default_nettype none

`include "pd_torque_limited_position_target_macros.svh"

module pdtl_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         psel,
  input logic         pwrite,
  input logic [31:0]  prdata,
  input logic         pready
);

  // An edge seen in reset leaves the result side empty at the next edge.
  `PDTL_ASSERT_NXT(a_reset_empty, clk_i, 1'b1, !rst_ni, !m_axis_tvalid, "result valid after reset")

  `PDTL_ASSERT_ALWAYS(a_pready_high, clk_i, pready, "pready dropped")

  // Both registers are at most 17 bits wide.
  `PDTL_ASSERT_IMP(a_prdata_width, clk_i, rst_ni, psel && !pwrite, prdata[31:17] == '0, "prdata has bits above the registers")

  `PDTL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind pd_torque_limited_position_target pdtl_chk u_chk (.*);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the PD torque limited position target block.
// A behavioral predictor recomputes every adjusted position from the joint
// fields and the current register settings. Results are checked in order
// against a queue of expected transfers; in some phases the stream sides idle at random.
module tb;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 78;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] adj;
    logic               clipped;
  } joint_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  pd_torque_limited_position_target #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers, used by the predictor.
  logic        clip_en_q = 1'b0;
  logic [16:0] cap_frac_q = 17'd65536;

  joint_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Exact PD torque kp*(qt-q) - kd*dq. 128 bits hold it without overflow.
  function automatic logic signed [127:0] pd_tau(input logic signed [63:0] qt,
      input logic signed [63:0] q, input logic signed [63:0] dq,
      input logic signed [63:0] kp, input logic signed [63:0] kd);
    logic signed [127:0] a;
    logic signed [127:0] b;
    a = 128'(kp) * (128'(qt) - 128'(q));
    b = 128'(kd) * 128'(dq);
    return a - b;
  endfunction

  // Target that yields +cap or -cap, truncated division, saturated to 32 bits.
  function automatic logic signed [63:0] solve_target(input logic signed [63:0] q,
      input logic signed [63:0] dq, input logic signed [63:0] kp,
      input logic signed [63:0] kd, input logic neg, input logic [63:0] cap);
    logic signed [127:0] num;
    logic signed [127:0] r;
    num = neg ? -$signed({64'd0, cap}) : $signed({64'd0, cap});
    num = num + 128'(kd) * 128'(dq);
    r = 128'(q) + num / 128'(kp);
    if (r > 128'sh7FFFFFFF) r = 128'sh7FFFFFFF;
    if (r < -128'sh80000000) r = -128'sh80000000;
    return 64'(r);
  endfunction

  function automatic joint_result_t predict_joint(input logic [191:0] d);
    logic signed [63:0] qt, q, dq, kp, kd, res;
    logic [63:0] lim, cap, full;
    logic signed [127:0] tau;
    logic [127:0] mag;
    joint_result_t r;
    qt = 64'($signed(d[31:0]));
    q = 64'($signed(d[63:32]));
    dq = 64'($signed(d[95:64]));
    kp = 64'($signed(d[127:96]));
    kd = 64'($signed(d[159:128]));
    lim = 64'(d[190:160]);
    res = qt;
    r.clipped = 1'b0;
    if (clip_en_q && lim != 0) begin
      if (kp == 0) begin
        res = q;
      end else begin
        cap = ((64'(cap_frac_q) * lim) << (FRAC_BITS - 16));
        full = lim << FRAC_BITS;
        tau = pd_tau(res, q, dq, kp, kd);
        mag = tau < 0 ? -tau : tau;
        if (mag > 128'(cap)) begin
          res = solve_target(q, dq, kp, kd, tau < 0, cap);
          r.clipped = 1'b1;
          tau = pd_tau(res, q, dq, kp, kd);
          mag = tau < 0 ? -tau : tau;
        end
        if (mag > 128'(full)) begin
          res = solve_target(q, dq, kp, kd, tau < 0, full);
          r.clipped = 1'b1;
        end
      end
    end
    r.adj = res[31:0];
    return r;
  endfunction

  // Register write: setup cycle, then the access cycle that commits it.
  task automatic write_reg(input pdtl_pkg::reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pdtl_pkg::REG_CLIP_EN) clip_en_q = value[0];
    else cap_frac_q = value[16:0];
  endtask

  // Sends one joint; the expectation is queued when the transfer happens.
  // tvalid stays high after the transfer so that joints can follow back to back.
  task automatic send_joint(input logic [191:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_joint(d));
  endtask

  function automatic logic [191:0] pack_joint(input logic [31:0] qt, input logic [31:0] q,
      input logic [31:0] dq, input logic [31:0] kp, input logic [31:0] kd,
      input logic [30:0] lim);
    return {1'b0, lim, kd, kp, dq, q, qt};
  endfunction

  // Mostly moderate values so that clamps really engage, with some full-range noise.
  function automatic logic [31:0] pick_val();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed(16'($urandom())));
      2: return 32'($signed(24'($urandom())));
      default: return 32'($signed(20'($urandom())));
    endcase
  endfunction

  function automatic logic [191:0] random_joint();
    logic [30:0] lim;
    case ($urandom_range(3))
      0: lim = 31'($urandom());
      1: lim = 31'($urandom_range(65535));
      default: lim = 31'($urandom_range(1 << 22));
    endcase
    if ($urandom_range(15) == 0) lim = '0;
    return pack_joint(pick_val(), pick_val(), pick_val(),
                      $urandom_range(15) == 0 ? 32'd0 : pick_val(), pick_val(), lim);
  endfunction

  // Stops sending, waits for every expected result, then lets the pipeline drain fully.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Result checker; the receiver stall follows the current phase.
  always @(posedge clk_i) begin
    joint_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no expectation waiting");
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== e.adj)
          report_mismatch($sformatf("adjusted_pos %h, expected %h", m_axis_tdata, e.adj));
        if (m_axis_tuser[0] !== e.clipped)
          report_mismatch($sformatf("was_clipped %b, expected %b", m_axis_tuser[0],
                                    e.clipped));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles without any transfer on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Extremes of every field, each operation path and each special case.
  task automatic test_directed();
    logic [31:0] mx = 32'h7FFFFFFF;
    logic [31:0] mn = 32'h80000000;
    // Disabled block passes every target through.
    send_joint(pack_joint(mx, mn, mx, mx, mn, 31'h7FFFFFFF));
    wait_idle();
    write_reg(pdtl_pkg::REG_CLIP_EN, 32'd1);
    // Zero limit passes through; zero kp returns the current position.
    send_joint(pack_joint(32'h12345678, 32'h1000, 0, 32'h10000, 0, 31'd0));
    send_joint(pack_joint(32'h12345678, 32'hABCD, 0, 32'd0, 32'h10000, 31'd100));
    // Small torque, no clamp; large torque in each direction.
    send_joint(pack_joint(32'h100, 0, 0, 32'h10000, 0, 31'h10000));
    send_joint(pack_joint(32'h100000, 0, 0, 32'h10000, 0, 31'h10000));
    send_joint(pack_joint(32'hFFF00000, 0, 0, 32'h10000, 0, 31'h10000));
    // Damping-dominated torque and negative gains.
    send_joint(pack_joint(0, 0, 32'h50000, 32'h10000, 32'h20000, 31'h10000));
    send_joint(pack_joint(32'h30000, 0, mn, mn, mx, 31'h1));
    // Back-solve that saturates high and low.
    send_joint(pack_joint(mx, mx, mx, 32'd1, mx, 31'h7FFFFFFF));
    send_joint(pack_joint(mn, mn, mn, 32'd1, mx, 31'h1));
    send_joint(pack_joint(mx, mn, mn, mx, mn, 31'h7FFFFFFF));
    send_joint(pack_joint(mn, mx, mx, mn, mn, 31'h7FFFFFFF));
    send_joint(pack_joint(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 31'h7FFFFFFF));
    wait_idle();
    // Smallest fraction: the first clamp is far below the full limit.
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'd1);
    send_joint(pack_joint(32'h40000, 0, 0, 32'h10000, 0, 31'h10000));
    send_joint(pack_joint(mx, mn, 32'h1234, 32'h2000, 32'h300, 31'h7FFFFFFF));
    wait_idle();
    // Out-of-range fractions: zero cap, and a cap above the limit.
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'd0);
    send_joint(pack_joint(32'h1, 0, 0, 32'h10000, 0, 31'h10000));
    wait_idle();
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'h1FFFF);
    send_joint(pack_joint(32'h40000, 0, 0, 32'h10000, 0, 31'h10000));
    send_joint(pack_joint(mx, 0, 0, mx, 0, 31'h7FFFFFFF));
    wait_idle();
  endtask

  // One randomized phase under a given idle and stall pressure.
  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_joint(random_joint());
    wait_idle();
  endtask

  task automatic test_config_sweep();
    write_reg(pdtl_pkg::REG_CLIP_EN, 32'd1);
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'd65536);
    test_random(450, 0, 0);
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'd32768);
    test_random(300, 88, 0);
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'd1);
    test_random(300, 0, 88);
    write_reg(pdtl_pkg::REG_CAP_FRAC, $urandom_range(65536, 1));
    test_random(350, 12, 12);
    write_reg(pdtl_pkg::REG_CLIP_EN, 32'd0);
    write_reg(pdtl_pkg::REG_CAP_FRAC, 32'h1FFFF);
    test_random(150, 12, 12);
    write_reg(pdtl_pkg::REG_CLIP_EN, 32'd1);
    test_random(200, 0, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
